[rtl/aprm_pkg.sv]
// ----------------------------------------------------------------------------
// aprm_pkg
// Shared constants, codes and types of the access policy rule matcher.
// ----------------------------------------------------------------------------
package aprm_pkg;

    localparam int MAX_RULES  = 16;
    localparam int NODE_COUNT = 256;
    localparam int WORD_W     = 64;
    localparam int SET_WORDS  = 4;
    localparam int SET_W      = WORD_W * SET_WORDS;
    localparam int NODE_W     = 8;
    localparam int CNT_W      = $clog2(MAX_RULES + 1);
    localparam int STORED_W   = 5;
    localparam int CMD_W      = 2;
    localparam int SEC_W      = 2;
    localparam int WIDX_W     = 2;
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_REQ_W0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_W1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_W2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_W3 = CFG_IDX_W'(3);

    localparam logic [SET_W-1:0] REQ_RESET = SET_W'(32);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [SEC_W-1:0] {
        SEC_SUBJ = 2'd0,
        SEC_OBJ  = 2'd1,
        SEC_ATTR = 2'd2,
        SEC_NONE = 2'd3
    } t_sec;

    typedef enum logic {
        ST_IDLE,
        ST_QUERY
    } t_state;

    typedef struct packed {
        logic [SET_W-1:0] subj;
        logic [SET_W-1:0] obj;
        logic [SET_W-1:0] attr;
    } t_rule;

    typedef struct packed {
        logic              active;
        logic              hit;
        logic [NODE_W-1:0] subj;
        logic [NODE_W-1:0] obj;
    } t_token;

endpackage

[rtl/aprm_if.sv]
// ----------------------------------------------------------------------------
// aprm_if
// Valid/ready channels of the matcher: command words, result words, config.
// ----------------------------------------------------------------------------
interface aprm_in_if;
    import aprm_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [SEC_W-1:0]  section;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] rule_word;
    logic [NODE_W-1:0] subject;
    logic [NODE_W-1:0] target_object;

    modport source (output valid, cmd, section, word_index, rule_word, subject,
                    target_object, input ready);
    modport sink   (input valid, cmd, section, word_index, rule_word, subject,
                    target_object, output ready);
endinterface

interface aprm_out_if;
    import aprm_pkg::*;

    logic                valid;
    logic                ready;
    logic                granted;
    logic                status;
    logic [STORED_W-1:0] rules_stored;

    modport source (output valid, granted, status, rules_stored, input ready);
    modport sink   (input valid, granted, status, rules_stored, output ready);
endinterface

interface aprm_cfg_if;
    import aprm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/aprm_cell.sv]
// ----------------------------------------------------------------------------
// aprm_cell
// One rule slot: holds a rule, shifts it on append, checks a passing query.
// ----------------------------------------------------------------------------
module aprm_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  aprm_pkg::t_rule             i_rule,
    input  logic                        i_valid,
    input  logic [aprm_pkg::SET_W-1:0]  i_req,
    input  aprm_pkg::t_token            i_tok,
    output aprm_pkg::t_rule             o_rule,
    output logic                        o_valid,
    output aprm_pkg::t_token            o_tok
);
    import aprm_pkg::*;

    t_rule  r_rule;
    logic   r_valid;
    t_token r_tok;
    logic   w_match;

    assign w_match = r_valid && r_rule.subj[i_tok.subj] && r_rule.obj[i_tok.obj]
                     && ((i_req & ~r_rule.attr) == '0);

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_rule <= i_rule;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok.hit  <= i_tok.hit || w_match;
        r_tok.subj <= i_tok.subj;
        r_tok.obj  <= i_tok.obj;
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_tok.active <= 1'b0;
        end else begin
            if (i_shift) begin
                r_valid <= i_valid;
            end
            r_tok.active <= i_tok.active;
        end
    end

    assign o_rule  = r_rule;
    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

[rtl/attribute_policy_rule_matcher_unit.sv]
// ----------------------------------------------------------------------------
// attribute_policy_rule_matcher_unit
// Access policy match engine over a row of rule cells.
// ----------------------------------------------------------------------------
// Channels: i_in takes command words (write pending word, append, query),
// o_out returns one result word per command, i_cfg writes the four 64-bit
// required-attribute registers (always ready, index beyond 3 is ignored).
// Write and append words are registered straight into the output register
// on the edge that takes them. An append to a table that is not full shifts
// every stored rule one cell down the row and loads the pending rule into
// the first cell. A query travels down the row of MAX_RULES cells, one cell
// per cycle, through each cell's token register and then the output
// register; the next word is taken once that result is out. Throughput is
// one word per cycle for writes and appends while the receiver takes results.
// Reset empties the table, clears the pending rule and sets the required
// attributes to bit 5. While the receiver stalls, the result holds and no
// new word is taken.
// ----------------------------------------------------------------------------
module attribute_policy_rule_matcher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aprm_in_if.sink     i_in,
    aprm_out_if.source  o_out,
    aprm_cfg_if.sink    i_cfg
);
    import aprm_pkg::*;

    t_state            r_state, n_state;
    logic [SET_W-1:0]  r_req;
    t_rule             r_pending, n_pending;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid;
    logic              r_granted;
    logic              r_status;
    logic [CNT_W-1:0]  r_stored;

    t_rule             w_rule  [MAX_RULES+1];
    logic              w_valid [MAX_RULES+1];
    t_token            w_tok   [MAX_RULES+1];

    t_cmd              w_cmd;
    t_sec              w_sec;
    logic              w_fire;
    logic              w_full;
    logic              w_shift;
    logic              w_in_range;
    logic              w_start;
    logic              w_done;

    assign w_cmd      = t_cmd'(i_in.cmd);
    assign w_sec      = t_sec'(i_in.section);
    assign w_fire     = i_in.valid && i_in.ready;
    assign w_full     = (32'(r_count) >= MAX_RULES);
    assign w_shift    = w_fire && (w_cmd == CMD_APPEND) && !w_full;
    assign w_in_range = (32'(i_in.subject) < NODE_COUNT)
                        && (32'(i_in.target_object) < NODE_COUNT);
    assign w_start    = w_fire && (w_cmd == CMD_QUERY) && w_in_range;
    assign w_done     = w_tok[MAX_RULES].active;

    // rule row
    assign w_rule[0]        = r_pending;
    assign w_valid[0]       = 1'b1;
    assign w_tok[0].active  = w_start;
    assign w_tok[0].hit     = 1'b0;
    assign w_tok[0].subj    = i_in.subject;
    assign w_tok[0].obj     = i_in.target_object;

    for (genvar k = 0; k < MAX_RULES; k++) begin : g_cell
        aprm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_rule  (w_rule[k]),
            .i_valid (w_valid[k]),
            .i_req   (r_req),
            .i_tok   (w_tok[k]),
            .o_rule  (w_rule[k+1]),
            .o_valid (w_valid[k+1]),
            .o_tok   (w_tok[k+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_QUERY;
                end
            end
            ST_QUERY: begin
                if (w_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready         = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
        i_cfg.ready        = 1'b1;
        o_out.valid        = r_out_valid;
        o_out.granted      = r_granted;
        o_out.status       = r_status;
        o_out.rules_stored = STORED_W'(r_stored);
    end

    // pending rule and count
    always_comb begin
        n_pending = r_pending;
        n_count   = r_count;
        if (w_fire) begin
            unique case (w_cmd)
                CMD_WRITE: begin
                    unique case (w_sec)
                        SEC_SUBJ: n_pending.subj[i_in.word_index*WORD_W +: WORD_W] =
                                      i_in.rule_word;
                        SEC_OBJ:  n_pending.obj[i_in.word_index*WORD_W +: WORD_W] =
                                      i_in.rule_word;
                        SEC_ATTR: n_pending.attr[i_in.word_index*WORD_W +: WORD_W] =
                                      i_in.rule_word;
                        SEC_NONE: n_pending = r_pending;
                        default:  n_pending = r_pending;
                    endcase
                end
                CMD_APPEND: begin
                    n_pending = '0;
                    if (!w_full) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_QUERY, CMD_NONE: n_pending = r_pending;
                default:             n_pending = r_pending;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pending   <= '0;
            r_count     <= '0;
            r_req       <= REQ_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_count   <= n_count;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_REQ_W0: r_req[0*WORD_W +: WORD_W] <= i_cfg.data;
                    CFG_REQ_W1: r_req[1*WORD_W +: WORD_W] <= i_cfg.data;
                    CFG_REQ_W2: r_req[2*WORD_W +: WORD_W] <= i_cfg.data;
                    CFG_REQ_W3: r_req[3*WORD_W +: WORD_W] <= i_cfg.data;
                    default:    r_req <= r_req;
                endcase
            end
            if ((w_fire && !w_start) || w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_granted <= w_tok[MAX_RULES].hit;
            r_status  <= 1'b0;
            r_stored  <= r_count;
        end else if (w_fire && !w_start) begin
            r_granted <= 1'b0;
            r_status  <= (w_cmd == CMD_APPEND) && w_full;
            r_stored  <= n_count;
        end
    end

endmodule
